// ===== rtl/core/rcpd_pkg.sv =====
// ---------------------------------------------------------------------------
// rcpd_pkg
// Shared types and constants of the rc pwm / cppm pulse decoder.
// ---------------------------------------------------------------------------
package rcpd_pkg;

    // register indexes on the configuration port (word address)
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [1:0] REG_SYNC_GAP  = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] MAX_WIDTH_RST = 16'd2500;
    localparam logic [15:0] SYNC_GAP_RST  = 16'd2100;

    // most results one sync edge can report
    localparam int RUN_MAX = 8;

    // slot index field wide enough for the largest supported slot count (16)
    localparam int SLOT_IDX_W = 4;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    typedef struct packed {
        logic        cppm_mode;
        logic [15:0] max_pulse_width;
        logic [15:0] sync_gap_min;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PWM  = 2'd0,
        CMD_SLOT = 2'd1,
        CMD_SYNC = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [SLOT_IDX_W-1:0]  idx;
        logic [15:0]            value;
    } cmd_t;

endpackage

// ===== rtl/core/rcpd_front.sv =====
// ---------------------------------------------------------------------------
// rcpd_front
// Accepts edge items, measures intervals and turns them into back-end
// commands: pwm width, slot write or frame sync.
// ---------------------------------------------------------------------------
module rcpd_front #(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcpd_pkg::cfg_t       cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [31:0]          edge_time,
    input  logic                 pin_level,
    input  logic                 q_full,
    output logic                 cmd_push,
    output rcpd_pkg::cmd_t       cmd
);
    import rcpd_pkg::*;

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [TIME_BITS-1:0] last_edge_reg;
    logic [TIME_BITS-1:0] last_edge_next;
    logic [CNT_W-1:0]     slot_count_reg;
    logic [CNT_W-1:0]     slot_count_next;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] span;
    logic                 accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign now    = TIME_BITS'(edge_time);
    assign span   = now - last_edge_reg;

    // classify the item
    always_comb
    begin
        last_edge_next  = last_edge_reg;
        slot_count_next = slot_count_reg;
        cmd_push        = 1'b0;
        cmd.kind        = CMD_PWM;
        cmd.idx         = SLOT_IDX_W'(slot_count_reg);
        cmd.value       = span[15:0];
        if (accept)
        begin
            if (!cfg.cppm_mode)
            begin
                if (pin_level)
                begin
                    last_edge_next = now;
                end
                else if (span <= TIME_BITS'(cfg.max_pulse_width))
                begin
                    cmd_push = 1'b1;
                end
            end
            else if (pin_level)
            begin
                last_edge_next = now;
                if (span > TIME_BITS'(cfg.sync_gap_min))
                begin
                    cmd.kind        = CMD_SYNC;
                    cmd_push        = 1'b1;
                    slot_count_next = '0;
                end
                else if (slot_count_reg < CNT_W'(NUM_SLOTS))
                begin
                    cmd.kind        = CMD_SLOT;
                    cmd_push        = 1'b1;
                    slot_count_next = slot_count_reg + 1'b1;
                end
            end
        end
    end

    // edge time and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            slot_count_reg <= '0;
        end
        else
        begin
            last_edge_reg  <= last_edge_next;
            slot_count_reg <= slot_count_next;
        end
    end

endmodule

// ===== rtl/core/rcpd_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// rcpd_cmd_fifo
// Short command queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module rcpd_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  rcpd_pkg::cmd_t   wr_cmd,
    output logic             q_full,
    input  logic             rd_en,
    output logic             rd_valid,
    output rcpd_pkg::cmd_t   rd_cmd
);
    import rcpd_pkg::*;

    localparam int CNT_W = CMDQ_PTR_W + 1;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign q_full   = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/rcpd_back.sv =====
// ---------------------------------------------------------------------------
// rcpd_back
// Executes commands: holds the channel slots, writes them and plays out
// a frame as a run of results into the output register.
// ---------------------------------------------------------------------------
module rcpd_back #(
    parameter int NUM_SLOTS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  rcpd_pkg::cmd_t   cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic             result_kind,
    output logic [2:0]       channel_index,
    output logic [15:0]      width_us,
    output logic             last_of_run
);
    import rcpd_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RUN_N  = (NUM_SLOTS < RUN_MAX) ? NUM_SLOTS : RUN_MAX;
    localparam int RUN_W  = (RUN_N > 1) ? $clog2(RUN_N) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [RUN_W-1:0] run_idx_reg;
    logic [RUN_W-1:0] run_idx_next;
    logic [15:0]     slot_reg [NUM_SLOTS];
    logic            slot_wr;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            kind_reg;
    logic            kind_next;
    logic [2:0]      index_reg;
    logic [2:0]      index_next;
    logic [15:0]     width_reg;
    logic [15:0]     width_next;
    logic            last_reg;
    logic            last_next;
    logic            out_free;
    logic            run_last;

    assign out_free = !out_valid_reg || pop;
    assign run_last = (run_idx_reg == RUN_W'(RUN_N - 1));

    assign empty         = !out_valid_reg;
    assign result_kind   = kind_reg;
    assign channel_index = index_reg;
    assign width_us      = width_reg;
    assign last_of_run   = last_reg;

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        run_idx_next   = run_idx_reg;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        index_next     = index_reg;
        width_next     = width_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        slot_wr        = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    index_next     = 3'(run_idx_reg);
                    width_next     = slot_reg[SLOT_W'(run_idx_reg)];
                    last_next      = run_last;
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        run_idx_next = run_idx_reg + 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_SLOT:
                        begin
                            slot_wr = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_SYNC:
                        begin
                            cmd_pop      = 1'b1;
                            run_idx_next = '0;
                            state_next   = ST_RUN;
                        end
                        CMD_PWM:
                        begin
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_valid_next = 1'b1;
                                kind_next      = 1'b0;
                                index_next     = 3'd0;
                                width_next     = cmd.value;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and channel slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
            if (slot_wr)
            begin
                slot_reg[cmd.idx[SLOT_W-1:0]] <= cmd.value;
            end
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        width_reg <= width_next;
        last_reg  <= last_next;
    end

endmodule

// ===== rtl/core/rc_pwm_cppm_pulse_decoder.sv =====
// ---------------------------------------------------------------------------
// rc_pwm_cppm_pulse_decoder
// RC receiver decoder: PWM high-width measurement or CPPM frame decoding
// from timestamped pin-edge items.
// ---------------------------------------------------------------------------
// Each pin edge is classified in the cycle it is accepted and may leave a
// command in a 4-deep queue; the back end drains that queue one command per
// cycle while it is idle and, for a PWM width, while the result register is
// free. A PWM width is loaded into the result register at the same edge at
// which the back end takes its command, so its path runs through the queue
// and then the result register. A slot write gives no result, and a frame
// sync plays out the stored channels as min(NUM_SLOTS, 8) results, one result
// per cycle while the result register is free. The input stalls (full high)
// only when the queue is full. Channel slots are flip-flops cleared at reset;
// no clearing pass is needed. Configuration may only be changed while the
// block is idle.
module rc_pwm_cppm_pulse_decoder #(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // edge items
    input  logic        push,
    output logic        full,
    input  logic [31:0] edge_time,
    input  logic        pin_level,
    // results
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [2:0]  channel_index,
    output logic [15:0] width_us,
    output logic        last_of_run
);
    import rcpd_pkg::*;

    cfg_t cfg_reg;
    logic cfg_wr;
    logic cmd_push;
    cmd_t front_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cppm_mode       <= 1'b0;
            cfg_reg.max_pulse_width <= MAX_WIDTH_RST;
            cfg_reg.sync_gap_min    <= SYNC_GAP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MODE:      cfg_reg.cppm_mode       <= pwdata[0];
                REG_MAX_WIDTH: cfg_reg.max_pulse_width <= pwdata[15:0];
                REG_SYNC_GAP:  cfg_reg.sync_gap_min    <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:      prdata = {31'd0, cfg_reg.cppm_mode};
            REG_MAX_WIDTH: prdata = {16'd0, cfg_reg.max_pulse_width};
            REG_SYNC_GAP:  prdata = {16'd0, cfg_reg.sync_gap_min};
            default:       prdata = 32'd0;
        endcase
    end

    // edge classification
    rcpd_front #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .edge_time (edge_time),
        .pin_level (pin_level),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    // command queue
    rcpd_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (front_cmd),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    // command execution and result output
    rcpd_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd           (q_cmd),
        .cmd_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .channel_index (channel_index),
        .width_us      (width_us),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== rtl/core/rcpd_checker.sv =====
// ---------------------------------------------------------------------------
// rcpd_checker
// Port-level checks of the pulse decoder result stream, bound to the top.
// ---------------------------------------------------------------------------
module rcpd_checker #(
    parameter int NUM_SLOTS = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        result_kind,
    input logic [2:0]  channel_index,
    input logic [15:0] width_us,
    input logic        last_of_run
);
    import rcpd_pkg::*;

    localparam int RUN_N = (NUM_SLOTS < RUN_MAX) ? NUM_SLOTS : RUN_MAX;

    // a pwm result is always a single-item run on channel zero
    a_pwm_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_kind) |-> (last_of_run && channel_index == 3'd0))
        else $error("pwm result not a single item on channel zero");

    // a frame run ends on the last reported slot
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind && last_of_run) |-> (channel_index == 3'(RUN_N - 1)))
        else $error("cppm run ended on the wrong slot");

    // inside a run the next channel follows right after a pop
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result_kind && !last_of_run) |=>
        (!empty && result_kind && channel_index == 3'($past(channel_index) + 3'd1)))
        else $error("cppm run broken or out of order");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(width_us) && $stable(channel_index)))
        else $error("waiting result changed before pop");

endmodule

bind rc_pwm_cppm_pulse_decoder rcpd_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_rcpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .channel_index (channel_index),
    .width_us      (width_us),
    .last_of_run   (last_of_run)
);

// ===== tb/sv/tb_rc_pwm_cppm_pulse_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_rc_pwm_cppm_pulse_decoder
// Self-checking bench for the rc pwm / cppm pulse decoder: timestamped pin
// edges go in, a built-in edge decoder predicts pulse widths and channel
// runs, and every popped result is compared field by field in order.
// ---------------------------------------------------------------------------
module tb_rc_pwm_cppm_pulse_decoder;

    import rcpd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 32;
    localparam int SLOTS         = 8;

    localparam logic MODE_PWM     = 1'b0;
    localparam logic MODE_CPPM    = 1'b1;
    localparam logic KIND_PWM     = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;
    localparam logic LEVEL_FALL   = 1'b0;
    localparam logic LEVEL_RISE   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  index;
        logic [15:0] width;
        logic        last;
    } pulse_result_t;

    // block ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] edge_time = '0;
    logic        pin_level = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        result_kind;
    logic [2:0]  channel_index;
    logic [15:0] width_us;
    logic        last_of_run;

    // decoder state as the bench sees it
    logic        model_mode = MODE_PWM;
    logic [15:0] model_max = MAX_WIDTH_RST;
    logic [15:0] model_sync = SYNC_GAP_RST;
    logic [31:0] rise_stamp = '0;
    logic [15:0] chan_slot [SLOTS] = '{default: '0};
    int          slot_fill = 0;

    pulse_result_t pending_pulses [$];
    pulse_result_t head;

    int          error_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] stamp = '0;

    always #(CLK_HALF) clk = ~clk;

    rc_pwm_cppm_pulse_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .edge_time     (edge_time),
        .pin_level     (pin_level),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .channel_index (channel_index),
        .width_us      (width_us),
        .last_of_run   (last_of_run)
    );

    // expected results of one accepted edge
    task automatic decode_edge(input logic [31:0] t, input logic lvl);
        logic [31:0]   span;
        pulse_result_t r;
        span = t - rise_stamp;
        if (model_mode == MODE_PWM) begin
            if (lvl == LEVEL_RISE)
                rise_stamp = t;
            else if (span <= {16'd0, model_max}) begin
                r = '{KIND_PWM, 3'd0, span[15:0], 1'b1};
                pending_pulses.push_back(r);
            end
            return;
        end
        // cppm: falling edges leave no trace
        if (lvl == LEVEL_FALL)
            return;
        rise_stamp = t;
        if (span > {16'd0, model_sync}) begin
            slot_fill = 0;
            for (int k = 0; k < SLOTS; k++) begin
                r = '{KIND_CHANNEL, 3'(k), chan_slot[k], k == SLOTS - 1};
                pending_pulses.push_back(r);
            end
        end else if (slot_fill < SLOTS) begin
            chan_slot[slot_fill] = span[15:0];
            slot_fill++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk) begin
        if (rst_n && !empty && pop) begin
            if (pending_pulses.size() == 0) begin
                $error("unexpected result: kind %0d index %0d width %0d last %0d",
                       result_kind, channel_index, width_us, last_of_run);
                error_count++;
            end else begin
                head = pending_pulses.pop_front();
                if (result_kind !== head.kind) begin
                    $error("result_kind expected %0d actual %0d", head.kind, result_kind);
                    error_count++;
                end
                if (channel_index !== head.index) begin
                    $error("channel_index expected %0d actual %0d", head.index, channel_index);
                    error_count++;
                end
                if (width_us !== head.width) begin
                    $error("width_us expected %0d actual %0d", head.width, width_us);
                    error_count++;
                end
                if (last_of_run !== head.last) begin
                    $error("last_of_run expected %0d actual %0d", head.last, last_of_run);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // send one edge item, idling in front of it at random
    task automatic send_edge(input logic [31:0] t, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        edge_time <= t;
        pin_level <= lvl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_edge(t, lvl);
        items_sent++;
    endtask

    // edge at a time offset from the previous one
    task automatic step_edge(input logic [31:0] delta, input logic lvl);
        stamp = stamp + delta;
        send_edge(stamp, lvl);
    endtask

    // stop sending and wait for every expected result
    task automatic wait_idle(input int settle);
        push <= 1'b0;
        @(posedge clk);
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // register write: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:      model_mode = val[0];
            REG_MAX_WIDTH: model_max  = val[15:0];
            REG_SYNC_GAP:  model_sync = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] random_limit(input int lo, input int hi);
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // pwm pulses with random widths around the limit, plus noise edges
    task automatic pwm_traffic(input int n);
        int start;
        int w;
        start = items_sent;
        while (items_sent - start < n) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(7) == 0)
                    w = int'(model_max) + $urandom_range(1);
                else
                    w = $urandom_range(0, int'(model_max) + int'(model_max) / 8 + 2);
                step_edge($urandom_range(1, 20000), LEVEL_RISE);
                step_edge(w, LEVEL_FALL);
                // second falling edge measures from the same rise
                if ($urandom_range(9) == 0)
                    step_edge($urandom_range(0, 100), LEVEL_FALL);
            end else
                send_edge($urandom, 1'($urandom_range(1)));
        end
    endtask

    // cppm frames: sync gap, then a run of channel intervals, plus noise
    task automatic cppm_traffic(input int n);
        int start;
        int nchan;
        int gap;
        start = items_sent;
        while (items_sent - start < n) begin
            if ($urandom_range(99) < 85) begin
                step_edge(int'(model_sync) + 1 + $urandom_range(0, 4000), LEVEL_RISE);
                nchan = ($urandom_range(3) != 0) ? SLOTS : $urandom_range(0, SLOTS + 3);
                for (int k = 0; k < nchan; k++) begin
                    case ($urandom_range(4))
                        0:       gap = int'(model_sync);
                        1:       gap = $urandom_range(0, int'(model_sync));
                        default: gap = (model_sync >= 16'd2100) ? $urandom_range(900, 2100)
                                                                 : $urandom_range(0, int'(model_sync));
                    endcase
                    if ($urandom_range(1))
                        send_edge(stamp + $urandom_range(0, 600), LEVEL_FALL);
                    step_edge(gap, LEVEL_RISE);
                end
            end else
                send_edge($urandom, 1'($urandom_range(1)));
        end
    endtask

    // one pwm stretch and one cppm stretch under the given idling
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n,
                                    input logic [15:0] max_val, input logic [15:0] sync_val,
                                    input bit pause);
        wait_idle(SETTLE_CYCLES);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_reg(REG_MODE, 32'(MODE_PWM));
        write_reg(REG_MAX_WIDTH, {16'd0, max_val});
        pwm_traffic(n / 2);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_MODE, 32'(MODE_CPPM));
        write_reg(REG_SYNC_GAP, {16'd0, sync_val});
        if (pause) begin
            cppm_traffic(n / 4);
            // sender holds off until the block has drained
            wait_idle(0);
            cppm_traffic(n - n / 2 - n / 4);
        end else
            cppm_traffic(n - n / 2);
    endtask

    task automatic test_pwm_directed();
        send_edge(32'd100, LEVEL_FALL);          // falling edge before any rise
        send_edge(32'd1000, LEVEL_RISE);
        send_edge(32'd2500, LEVEL_FALL);
        send_edge(32'd3500, LEVEL_FALL);         // width equal to the limit
        send_edge(32'd3501, LEVEL_FALL);         // one past the limit, dropped
        send_edge(32'hFFFF_FF00, LEVEL_RISE);
        send_edge(32'h0000_0100, LEVEL_FALL);    // timer wrap
        send_edge(32'hFFFF_FFFF, LEVEL_RISE);
        send_edge(32'hFFFF_FFFF, LEVEL_FALL);    // zero width
    endtask

    task automatic test_cppm_directed();
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_MODE, 32'(MODE_CPPM));
        stamp = 32'h8000_0000;
        send_edge(stamp, LEVEL_RISE);            // sync with slots still clear
        send_edge(stamp + 300, LEVEL_FALL);      // ignored in cppm
        step_edge(32'd2100, LEVEL_RISE);         // interval at threshold fills a slot
        step_edge(32'd0, LEVEL_RISE);
        for (int k = 0; k < 6; k++)
            step_edge(32'd1000 + 32'(100 * k), LEVEL_RISE);
        step_edge(32'd1600, LEVEL_RISE);         // slots full, dropped
        step_edge(32'd2101, LEVEL_RISE);         // sync
        step_edge(32'd1234, LEVEL_RISE);
        step_edge(32'd1500, LEVEL_RISE);
        step_edge(32'd40000, LEVEL_RISE);        // sync, upper slots stale
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0, 104, 16'hFFFF, 16'h0000, 1'b0);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(49, 0, 104, 16'h0000, 16'hFFFF, 1'b1);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(0, 49, 104, random_limit(1000, 3000), random_limit(1800, 3000), 1'b0);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(29, 29, 108, random_limit(1000, 3000), random_limit(1800, 3000), 1'b0);
    endtask

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // test sequence
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pwm_directed();
        test_cppm_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        wait_idle(SETTLE_CYCLES);
        if (error_count == 0 && pending_pulses.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
